// ----- design/lpfb_pkg.sv -----
// ----------------------------------------------------------------------------
// lpfb_pkg: shared types and constants for the framer
// Framing constants, queue sizing, command codes and the crc byte function.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfb_pkg;

	// framing constants
	localparam logic [7:0]  SOF_A     = 8'hAA;
	localparam logic [7:0]  SOF_B     = 8'h55;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [8:0]  OVERHEAD  = 9'd5;
	localparam logic [8:0]  CAP_RESET = 9'd260;

	// command queue sizing
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// command kinds
	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_ZERO   = 2'd1;
	localparam logic [1:0] CMD_DATA   = 2'd2;
	localparam logic [1:0] CMD_REJECT = 2'd3;

	// output byte positions within a frame
	localparam logic [2:0] STEP_SOF_A  = 3'd0;
	localparam logic [2:0] STEP_SOF_B  = 3'd1;
	localparam logic [2:0] STEP_LEN    = 3'd2;
	localparam logic [2:0] STEP_DATA   = 3'd3;
	localparam logic [2:0] STEP_CRC_HI = 3'd4;
	localparam logic [2:0] STEP_CRC_LO = 3'd5;

	// one classified request handed from front to back
	typedef struct packed {
		logic [1:0] kind;
		logic       last;
		logic [7:0] data;
		logic [7:0] len;
	} cmd_t;

	// crc-16/ccitt-false update by one byte, msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- design/lpfb_if.sv -----
// ----------------------------------------------------------------------------
// lpfb_if: stream channels of the framer
// Input byte channel and framed output byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [7:0] frame_length;

	modport source (output valid, output data_byte, output frame_length, input ready);
	modport sink   (input valid, input data_byte, input frame_length, output ready);
endinterface

interface lpfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       rejected;

	modport source (output valid, output out_byte, output frame_end, output rejected,
		input ready);
	modport sink   (input valid, input out_byte, input frame_end, input rejected,
		output ready);
endinterface

`default_nettype wire

// ----- design/lpfb_front.sv -----
// ----------------------------------------------------------------------------
// lpfb_front: request classifier
// Tracks frame position, checks capacity; all but rejected tails make commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfb_front
	import lpfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [8:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] frame_length,
	output logic            push_valid,
	input  wire logic       push_ready,
	output cmd_t            push_cmd
);

	logic [8:0] cap_q;
	logic [7:0] bytes_left_q;
	logic       in_frame_q;
	logic       discarding_q;
	logic       accepted;
	logic       too_big;

	assign in_ready = push_ready;
	assign accepted = in_valid && in_ready;
	assign too_big  = ({1'b0, frame_length} + OVERHEAD) > cap_q;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// classify the request
	always_comb begin
		push_valid    = 1'b0;
		push_cmd.kind = CMD_DATA;
		push_cmd.last = 1'b0;
		push_cmd.data = data_byte;
		push_cmd.len  = frame_length;
		if (accepted && !discarding_q) begin
			push_valid = 1'b1;
			if (in_frame_q) begin
				push_cmd.kind = CMD_DATA;
				push_cmd.last = (bytes_left_q == 8'd1);
			end else if (too_big) begin
				push_cmd.kind = CMD_REJECT;
			end else if (frame_length == 8'd0) begin
				push_cmd.kind = CMD_ZERO;
			end else begin
				push_cmd.kind = CMD_START;
				push_cmd.last = (frame_length == 8'd1);
			end
		end
	end

	// frame position tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 8'd0;
			in_frame_q   <= 1'b0;
			discarding_q <= 1'b0;
		end else if (accepted) begin
			if (discarding_q) begin
				bytes_left_q <= bytes_left_q - 8'd1;
				if (bytes_left_q == 8'd1) begin
					discarding_q <= 1'b0;
				end
			end else if (in_frame_q) begin
				bytes_left_q <= bytes_left_q - 8'd1;
				if (bytes_left_q == 8'd1) begin
					in_frame_q <= 1'b0;
				end
			end else if (too_big) begin
				if (frame_length > 8'd1) begin
					bytes_left_q <= frame_length - 8'd1;
					discarding_q <= 1'b1;
				end
			end else if (frame_length > 8'd1) begin
				bytes_left_q <= frame_length - 8'd1;
				in_frame_q   <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/lpfb_queue.sv -----
// ----------------------------------------------------------------------------
// lpfb_queue: command queue
// Small flop queue between classifier and byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfb_queue
	import lpfb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire cmd_t  push_cmd,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output cmd_t       pop_cmd
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/lpfb_back.sv -----
// ----------------------------------------------------------------------------
// lpfb_back: byte sequencer
// Emits header, payload and crc bytes or reject markers via an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfb_back
	import lpfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       head_valid,
	output logic            head_pop,
	input  wire cmd_t       head_cmd,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            frame_end,
	output logic            rejected
);

	logic [2:0]  step_q;
	logic        started_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        frame_end_q;
	logic        rejected_q;

	logic [2:0]  eff_step;
	logic [2:0]  next_step;
	logic [7:0]  nxt_byte;
	logic        nxt_end;
	logic        nxt_rej;
	logic        done;
	logic        advance;

	assign advance  = head_valid && (!out_valid_q || out_ready);
	assign head_pop = advance && done;
	assign eff_step = started_q ? step_q
		: ((head_cmd.kind == CMD_DATA) ? STEP_DATA : STEP_SOF_A);

	// byte selection for the current step
	always_comb begin
		nxt_byte  = 8'h00;
		nxt_end   = 1'b0;
		nxt_rej   = 1'b0;
		done      = 1'b0;
		next_step = STEP_SOF_A;
		case (eff_step)
			STEP_SOF_A: begin
				nxt_byte  = SOF_A;
				next_step = STEP_SOF_B;
			end
			STEP_SOF_B: begin
				nxt_byte  = SOF_B;
				next_step = STEP_LEN;
			end
			STEP_LEN: begin
				nxt_byte  = head_cmd.len;
				next_step = (head_cmd.kind == CMD_ZERO) ? STEP_CRC_HI : STEP_DATA;
			end
			STEP_DATA: begin
				nxt_byte  = head_cmd.data;
				next_step = STEP_CRC_HI;
				done      = !head_cmd.last;
			end
			STEP_CRC_HI: begin
				nxt_byte  = crc_q[15:8];
				next_step = STEP_CRC_LO;
			end
			STEP_CRC_LO: begin
				nxt_byte = crc_q[7:0];
				nxt_end  = 1'b1;
				done     = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
		// rejection is a single marker byte
		if (head_cmd.kind == CMD_REJECT) begin
			nxt_byte = 8'h00;
			nxt_end  = 1'b1;
			nxt_rej  = 1'b1;
			done     = 1'b1;
		end
	end

	// step tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_SOF_A;
			started_q <= 1'b0;
		end else if (advance) begin
			step_q    <= next_step;
			started_q <= !done;
		end
	end

	// running crc over payload bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (advance && head_cmd.kind != CMD_REJECT) begin
			if (eff_step == STEP_SOF_A || eff_step == STEP_CRC_LO) begin
				crc_q <= CRC_INIT;
			end else if (eff_step == STEP_DATA) begin
				crc_q <= crc_byte(crc_q, head_cmd.data);
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q  <= nxt_byte;
			frame_end_q <= nxt_end;
			rejected_q  <= nxt_rej;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign rejected  = rejected_q;

endmodule

`default_nettype wire

// ----- design/length_prefixed_frame_builder_crc16_top.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_frame_builder_crc16_top: length-prefixed framer with crc-16
// Frames payload bytes as AA 55 LEN payload CRC_HI CRC_LO, rejecting oversize frames.
// ----------------------------------------------------------------------------
// channel   dir  handshake     payload
// in_ch     in   valid/ready   data_byte[7:0], frame_length[7:0]
// out_ch    out  valid/ready   out_byte[7:0], frame_end, rejected
// cfg       in   cfg_we        cfg_wdata[8:0] = out_capacity
//
// a payload request is taken every cycle while the 4-entry command queue has room.
// the sequencer emits one byte per cycle while out_ch is not stalled: a frame start adds
// three header bytes and the last byte two crc bytes; the queue absorbs these.
// reset clears frame tracking, the queue and the output register; capacity returns to 260.
// an output stall fills the queue, after which in_ch.ready drops.
`default_nettype none

module length_prefixed_frame_builder_crc16_top
	import lpfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	lpfb_in_if.sink         in_ch,
	lpfb_out_if.source      out_ch,
	input  wire logic       cfg_we,
	input  wire logic [8:0] cfg_wdata
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic head_valid;
	logic head_pop;
	cmd_t head_cmd;

	// request classifier
	lpfb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.data_byte    (in_ch.data_byte),
		.frame_length (in_ch.frame_length),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_cmd     (push_cmd)
	);

	// command queue
	lpfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (head_valid),
		.pop_ready  (head_pop),
		.pop_cmd    (head_cmd)
	);

	// byte sequencer
	lpfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head_cmd   (head_cmd),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_byte   (out_ch.out_byte),
		.frame_end  (out_ch.frame_end),
		.rejected   (out_ch.rejected)
	);

endmodule

`default_nettype wire

// ----- design/lpfb_checker.sv -----
// ----------------------------------------------------------------------------
// lpfb_checker: port-level checks for the framer
// Watches the output channel for rejection marking and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       frame_end,
	input wire logic       rejected
);

	// a rejection always closes the frame
	a_reject_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> frame_end)
		else $error("rejection without frame_end");

	// a rejection carries a zero byte
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> out_byte == 8'h00)
		else $error("rejection with nonzero byte");

	// a stalled byte stays put
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(frame_end) && $stable(rejected))
		else $error("output changed under stall");

endmodule

bind length_prefixed_frame_builder_crc16_top lpfb_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.frame_end (out_ch.frame_end),
	.rejected  (out_ch.rejected)
);

`default_nettype wire

// ----- tb/sv/lpfb_stream_check.sv -----
// ----------------------------------------------------------------------------
// lpfb_stream_check: framed byte predictor and comparator
// Watches the input, output and capacity ports of the framer. Each accepted
// input request is turned into the framed bytes it must produce. Each
// accepted output request is checked field by field against the oldest of them.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfb_stream_check
	import lpfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	lpfb_in_if              in_mon,
	lpfb_out_if             out_mon,
	input  wire logic       cfg_we,
	input  wire logic [8:0] cfg_wdata,
	output int              mismatches,
	output int              pending,
	output int              results_seen,
	output int              rejects_seen,
	output int              frames_seen
);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       rejected;
	} framed_byte_t;

	framed_byte_t bytes_due[$];

	// shadow of the framer state
	logic [8:0]  capacity;
	logic [15:0] crc;
	logic [7:0]  bytes_left;
	logic        in_frame;
	logic        discarding;

	// crc-16/ccitt-false, one bit at a time, msb first
	function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c;
		for (int i = 7; i >= 0; i--) begin
			if (r[15] ^ b[i]) begin
				r = {r[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

	// append both crc bytes and go back to idle
	task automatic close_frame();
		bytes_due.push_back('{crc[15:8], 1'b0, 1'b0});
		bytes_due.push_back('{crc[7:0], 1'b1, 1'b0});
		crc        = CRC_INIT;
		in_frame   = 1'b0;
		bytes_left = 8'd0;
	endtask

	// framed bytes caused by one input request
	task automatic build_frame_bytes(input logic [7:0] d, input logic [7:0] l);
		if (discarding) begin
			bytes_left = bytes_left - 8'd1;
			if (bytes_left == 8'd0) begin
				discarding = 1'b0;
			end
		end else if (in_frame) begin
			bytes_due.push_back('{d, 1'b0, 1'b0});
			crc        = crc16_update(crc, d);
			bytes_left = bytes_left - 8'd1;
			if (bytes_left == 8'd0) begin
				close_frame();
			end
		end else if ({1'b0, l} + OVERHEAD > capacity) begin
			frames_seen++;
			bytes_due.push_back('{8'd0, 1'b1, 1'b1});
			if (l > 8'd1) begin
				bytes_left = l - 8'd1;
				discarding = 1'b1;
			end
		end else begin
			frames_seen++;
			crc = CRC_INIT;
			bytes_due.push_back('{SOF_A, 1'b0, 1'b0});
			bytes_due.push_back('{SOF_B, 1'b0, 1'b0});
			bytes_due.push_back('{l, 1'b0, 1'b0});
			if (l == 8'd0) begin
				close_frame();
			end else begin
				bytes_due.push_back('{d, 1'b0, 1'b0});
				crc        = crc16_update(crc, d);
				bytes_left = l - 8'd1;
				in_frame   = 1'b1;
				if (bytes_left == 8'd0) begin
					close_frame();
				end
			end
		end
	endtask

	// compare one output request with the oldest expected byte
	task automatic check_out_byte(input logic [7:0] b, input logic e, input logic r);
		framed_byte_t want;
		results_seen++;
		if (r) begin
			rejects_seen++;
		end
		if (bytes_due.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result out_byte=%h frame_end=%b rejected=%b",
				$time, b, e, r);
		end else begin
			want = bytes_due.pop_front();
			if (want.out_byte !== b) begin
				mismatches++;
				$display("%0t: out_byte expected %h actual %h", $time, want.out_byte, b);
			end
			if (want.frame_end !== e) begin
				mismatches++;
				$display("%0t: frame_end expected %b actual %b", $time, want.frame_end, e);
			end
			if (want.rejected !== r) begin
				mismatches++;
				$display("%0t: rejected expected %b actual %b", $time, want.rejected, r);
			end
		end
	endtask

	// watch all channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity     = CAP_RESET;
			crc          = CRC_INIT;
			bytes_left   = 8'd0;
			in_frame     = 1'b0;
			discarding   = 1'b0;
			bytes_due.delete();
			mismatches   = 0;
			pending      = 0;
			results_seen = 0;
			rejects_seen = 0;
			frames_seen  = 0;
		end else begin
			if (in_mon.valid && in_mon.ready) begin
				build_frame_bytes(in_mon.data_byte, in_mon.frame_length);
			end
			if (out_mon.valid && out_mon.ready) begin
				check_out_byte(out_mon.out_byte, out_mon.frame_end, out_mon.rejected);
			end
			// a write takes effect for frames that start later
			if (cfg_we) begin
				capacity = cfg_wdata;
			end
			pending = bytes_due.size();
		end
	end

endmodule

`default_nettype wire

// ----- tb/sv/length_prefixed_frame_builder_crc16_top_tb.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_frame_builder_crc16_top_tb: framer testbench
// Drives payload requests and capacity settings into the framer with random
// gaps on both channels. A directed opening covers zero-length, single-byte
// and rejected frames at boundary capacities; random frames of mostly small
// sizes and one of the largest size follow. The stream checker predicts and
// compares every framed byte.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_builder_crc16_top_tb
	import lpfb_pkg::*;
();

	localparam int IDLE_MAX     = 10;
	localparam int RAND_ITEMS   = 285;
	localparam int PHASE_ITEMS  = 10;
	localparam int DRAIN_PAUSE  = 16;
	localparam int STALL_LIMIT  = 2000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [8:0] cfg_wdata;

	int in_idle_max;
	int out_idle_max;
	int items_sent;
	int cap_writes;

	int mismatches;
	int pending;
	int results_seen;
	int rejects_seen;
	int frames_seen;

	lpfb_in_if  in_ch ();
	lpfb_out_if out_ch ();

	length_prefixed_frame_builder_crc16_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	lpfb_stream_check u_stream_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_mon       (in_ch),
		.out_mon      (out_ch),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen),
		.rejects_seen (rejects_seen),
		.frames_seen  (frames_seen)
	);

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// payload byte, biased toward the extremes
	function automatic logic [7:0] pick_data();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly short frames, some longer ones
	function automatic logic [7:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return 8'd0;
		end else if (r < 25) begin
			return 8'd1;
		end else if (r < 85) begin
			return 8'($urandom_range(2, 8));
		end
		return 8'($urandom_range(9, 40));
	endfunction

	function automatic logic [8:0] pick_capacity();
		case ($urandom_range(0, 6))
			0: return 9'd0;
			1: return OVERHEAD;
			2: return OVERHEAD + 9'd1;
			3: return 9'($urandom_range(7, 45));
			4: return CAP_RESET - 9'd1;
			5: return CAP_RESET;
			default: return 9'($urandom_range(261, 511));
		endcase
	endfunction

	// gap setting for the next phase, sometimes none on either side
	task automatic pick_idling();
		case ($urandom_range(0, 3))
			0: begin
				in_idle_max  = 0;
				out_idle_max = 0;
			end
			1: begin
				in_idle_max  = IDLE_MAX;
				out_idle_max = 0;
			end
			2: begin
				in_idle_max  = 0;
				out_idle_max = IDLE_MAX;
			end
			default: begin
				in_idle_max  = IDLE_MAX;
				out_idle_max = IDLE_MAX;
			end
		endcase
	endtask

	// one input request, called and left at a falling edge
	task automatic send_item(input logic [7:0] d, input logic [7:0] l);
		int gap;
		gap = $urandom_range(0, in_idle_max);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.data_byte    <= d;
		in_ch.frame_length <= l;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// a whole frame: later requests carry a noise length
	task automatic send_frame(input logic [7:0] l);
		int n;
		n = (l == 8'd0) ? 1 : int'(l);
		send_item(pick_data(), l);
		for (int k = 1; k < n; k++) begin
			send_item(pick_data(), 8'($urandom_range(0, 255)));
		end
	endtask

	// write capacity once the framer has drained
	task automatic set_capacity(input logic [8:0] v);
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cap_writes++;
	endtask

	// output side backpressure
	initial begin : out_ready_drive
		int gap;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = $urandom_range(0, out_idle_max);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// watchdog on cycles without any request
	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				stalled = 0;
			end else begin
				stalled++;
			end
		end
		$display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int rand_start;
		int phase_start;
		int rand_phase;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = CAP_RESET;
		in_ch.valid        = 1'b0;
		in_ch.data_byte    = 8'd0;
		in_ch.frame_length = 8'd0;
		in_idle_max        = 0;
		out_idle_max       = 0;
		items_sent         = 0;
		cap_writes         = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero-length, single-byte and short frames at the reset capacity
		set_capacity(CAP_RESET);
		pick_idling();
		send_item(8'hFF, 8'd0);
		send_item(8'h00, 8'd1);
		send_item(8'hFF, 8'd1);
		send_item(8'hFF, 8'd3);
		send_item(8'h00, 8'hFF);
		send_item(8'hA5, 8'h00);

		// capacity at the header size: only empty frames fit
		set_capacity(OVERHEAD);
		pick_idling();
		send_item(pick_data(), 8'd0);
		send_item(8'h00, 8'd1);
		send_frame(8'd4);
		send_item(pick_data(), 8'd0);

		// zero capacity rejects even an empty frame
		set_capacity(9'd0);
		pick_idling();
		send_item(pick_data(), 8'd0);
		send_frame(8'd2);

		// one payload byte fits exactly
		set_capacity(OVERHEAD + 9'd1);
		pick_idling();
		send_item(pick_data(), 8'd1);
		send_frame(8'd2);

		// widest capacity value
		set_capacity(9'h1FF);
		pick_idling();
		send_item(8'h00, 8'd5);
		send_item(8'hFF, 8'($urandom_range(0, 255)));
		send_item(8'h01, 8'($urandom_range(0, 255)));
		send_item(8'h80, 8'($urandom_range(0, 255)));
		send_item(8'h7F, 8'($urandom_range(0, 255)));

		// random phases, the first one with the longest frame
		rand_start = items_sent;
		rand_phase = 0;
		while (items_sent - rand_start < RAND_ITEMS) begin
			set_capacity((rand_phase == 0) ? CAP_RESET : pick_capacity());
			pick_idling();
			phase_start = items_sent;
			if (rand_phase == 0) begin
				send_frame(8'd255);
			end
			while (items_sent - phase_start < PHASE_ITEMS
				|| (rand_phase == 0 && items_sent - phase_start < 255 + PHASE_ITEMS)) begin
				// now and then hold off until the framer has drained
				if ($urandom_range(0, 7) == 0) begin
					in_ch.valid <= 1'b0;
					do @(negedge clk); while (pending != 0);
				end
				send_frame(pick_length());
			end
			rand_phase++;
		end

		// drain and let any swallowed bytes clear
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);

		$display("sent %0d payload requests in %0d frames over %0d capacity settings",
			items_sent, frames_seen, cap_writes);
		$display("checked %0d framed bytes, %0d of them rejections, %0d mismatches",
			results_seen, rejects_seen, mismatches);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/lpfb_pkg.sv
design/lpfb_if.sv
design/lpfb_front.sv
design/lpfb_queue.sv
design/lpfb_back.sv
design/length_prefixed_frame_builder_crc16_top.sv
design/lpfb_checker.sv
tb/sv/lpfb_stream_check.sv
tb/sv/length_prefixed_frame_builder_crc16_top_tb.sv
